// ===== rtl/pit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_pkg
// shared widths, beat types and codes of the point-in-triangle test unit
// ----------------------------------------------------------------------------
package pit_pkg;

    // coordinate width of every vertex and query point field
    localparam int COORD_WIDTH = 16;

    // register widths
    localparam int TOL_W  = 32;
    localparam int ETOL_W = 16;
    localparam int LIM_W  = 32;

    // fraction bits of the edge band tolerance
    localparam int EDGE_FRAC = 16;

    // datapath widths, all exact
    localparam int DIFF_W  = COORD_WIDTH + 1;       // vertex differences
    localparam int PROD_W  = 2 * DIFF_W;            // difference products
    localparam int DOT_W   = PROD_W + 2;            // three-term dot products
    localparam int NRM_W   = PROD_W + 1;            // normal components
    localparam int DD_W    = 2 * DOT_W;             // dot by dot products
    localparam int NC_W    = NRM_W + DIFF_W;        // normal by offset products
    localparam int GRAM_W  = DD_W + 1;              // gram determinant, u and v numerators
    localparam int BARY_W  = GRAM_W + 2;            // w numerator
    localparam int PLANE_W = NC_W + 2;              // plane offset numerator
    localparam int SQ_W    = 2 * PLANE_W;           // squared plane offset
    localparam int TOLN_W  = TOL_W + 1 + GRAM_W;    // plane tolerance times gram
    localparam int ETN_W   = ETOL_W + 1 + GRAM_W;   // edge tolerance times gram
    localparam int OFF_W   = (SQ_W > TOLN_W) ? SQ_W : TOLN_W;
    localparam int CLS_W   = BARY_W + EDGE_FRAC + 1;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_PLANE_TOL = 2'd0;
    localparam logic [1:0] REG_EDGE_TOL  = 2'd1;
    localparam logic [1:0] REG_DEGEN_LIM = 2'd2;

    localparam logic [TOL_W-1:0]  PLANE_TOL_RESET = '0;
    localparam logic [ETOL_W-1:0] EDGE_TOL_RESET  = 16'd1;
    localparam logic [LIM_W-1:0]  DEGEN_LIM_RESET = '0;

    // region codes
    localparam logic [1:0] REGION_OUTSIDE = 2'd0;
    localparam logic [1:0] REGION_EDGE    = 2'd1;
    localparam logic [1:0] REGION_INSIDE  = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] az;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by_coord;
        logic signed [COORD_WIDTH-1:0] bz;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [COORD_WIDTH-1:0] pz;
    } t_pit_in;

    typedef struct packed {
        logic [1:0] region;
        logic       off_plane;
        logic       degenerate;
    } t_pit_out;

endpackage
`default_nettype wire

// ===== rtl/pit_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_mul
// two-stage signed multiplier, operands split in halves into four partial
// products, summed in the second stage
// ----------------------------------------------------------------------------
module pit_mul #(
    parameter int AW = 36,
    parameter int BW = 36
) (
    input  logic                  i_clk,
    input  logic                  i_en_pp,
    input  logic                  i_en_sum,
    input  logic signed [AW-1:0]  i_a,
    input  logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic signed [AH-1:0]      a_hi;
    logic signed [AL:0]        a_lo;
    logic signed [BH-1:0]      b_hi;
    logic signed [BL:0]        b_lo;

    logic signed [AH+BH-1:0]   r_hh;
    logic signed [AH+BL:0]     r_hl;
    logic signed [AL+BH:0]     r_lh;
    logic        [AL+BL-1:0]   r_ll;

    logic        [PW-1:0]      n_p;

    // low halves are unsigned, carried with a zero sign bit
    assign a_hi = i_a[AW-1:AL];
    assign a_lo = $signed({1'b0, i_a[AL-1:0]});
    assign b_hi = i_b[BW-1:BL];
    assign b_lo = $signed({1'b0, i_b[BL-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_hh <= a_hi * b_hi;
            r_hl <= a_hi * b_lo;
            r_lh <= a_lo * b_hi;
            r_ll <= i_a[AL-1:0] * i_b[BL-1:0];
        end
    end

    // modular sum, exact because the true product fits in PW bits
    assign n_p = (PW'(r_hh) << (AL + BL)) + (PW'(r_hl) << AL)
               + (PW'(r_lh) << BL) + PW'(r_ll);

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            o_p <= $signed(n_p);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pit_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_front
// edge vectors, their element products and the dot products and normal
// ----------------------------------------------------------------------------
module pit_front
    import pit_pkg::*;
(
    input  logic                     i_clk,
    input  logic [2:0]               i_en,
    input  t_pit_in                  i_item,
    output logic signed [DOT_W-1:0]  o_daa,
    output logic signed [DOT_W-1:0]  o_dab,
    output logic signed [DOT_W-1:0]  o_dac,
    output logic signed [DOT_W-1:0]  o_dbb,
    output logic signed [DOT_W-1:0]  o_dbc,
    output logic signed [NRM_W-1:0]  o_nx,
    output logic signed [NRM_W-1:0]  o_ny,
    output logic signed [NRM_W-1:0]  o_nz,
    output logic signed [DIFF_W-1:0] o_cx,
    output logic signed [DIFF_W-1:0] o_cy,
    output logic signed [DIFF_W-1:0] o_cz
);

    logic signed [DIFF_W-1:0] n_a [3];
    logic signed [DIFF_W-1:0] n_b [3];
    logic signed [DIFF_W-1:0] n_c [3];

    logic signed [DIFF_W-1:0] r1_a [3];
    logic signed [DIFF_W-1:0] r1_b [3];
    logic signed [DIFF_W-1:0] r1_c [3];

    // element products: aa, ab, ac, bb, bc, three lanes each
    logic signed [PROD_W-1:0] r2_aa [3];
    logic signed [PROD_W-1:0] r2_ab [3];
    logic signed [PROD_W-1:0] r2_ac [3];
    logic signed [PROD_W-1:0] r2_bb [3];
    logic signed [PROD_W-1:0] r2_bc [3];
    // cross terms a1b2, a2b1, a2b0, a0b2, a0b1, a1b0
    logic signed [PROD_W-1:0] r2_x  [6];
    logic signed [DIFF_W-1:0] r2_c  [3];

    // a = C - A, b = B - A, c = P - A
    always_comb begin
        n_a[0] = DIFF_W'(i_item.cx) - DIFF_W'(i_item.ax);
        n_a[1] = DIFF_W'(i_item.cy) - DIFF_W'(i_item.ay);
        n_a[2] = DIFF_W'(i_item.cz) - DIFF_W'(i_item.az);
        n_b[0] = DIFF_W'(i_item.bx) - DIFF_W'(i_item.ax);
        n_b[1] = DIFF_W'(i_item.by_coord) - DIFF_W'(i_item.ay);
        n_b[2] = DIFF_W'(i_item.bz) - DIFF_W'(i_item.az);
        n_c[0] = DIFF_W'(i_item.px) - DIFF_W'(i_item.ax);
        n_c[1] = DIFF_W'(i_item.py) - DIFF_W'(i_item.ay);
        n_c[2] = DIFF_W'(i_item.pz) - DIFF_W'(i_item.az);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_a <= n_a;
            r1_b <= n_b;
            r1_c <= n_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int k = 0; k < 3; k++) begin
                r2_aa[k] <= r1_a[k] * r1_a[k];
                r2_ab[k] <= r1_a[k] * r1_b[k];
                r2_ac[k] <= r1_a[k] * r1_c[k];
                r2_bb[k] <= r1_b[k] * r1_b[k];
                r2_bc[k] <= r1_b[k] * r1_c[k];
            end
            r2_x[0] <= r1_a[1] * r1_b[2];
            r2_x[1] <= r1_a[2] * r1_b[1];
            r2_x[2] <= r1_a[2] * r1_b[0];
            r2_x[3] <= r1_a[0] * r1_b[2];
            r2_x[4] <= r1_a[0] * r1_b[1];
            r2_x[5] <= r1_a[1] * r1_b[0];
            r2_c    <= r1_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_daa <= DOT_W'(r2_aa[0]) + DOT_W'(r2_aa[1]) + DOT_W'(r2_aa[2]);
            o_dab <= DOT_W'(r2_ab[0]) + DOT_W'(r2_ab[1]) + DOT_W'(r2_ab[2]);
            o_dac <= DOT_W'(r2_ac[0]) + DOT_W'(r2_ac[1]) + DOT_W'(r2_ac[2]);
            o_dbb <= DOT_W'(r2_bb[0]) + DOT_W'(r2_bb[1]) + DOT_W'(r2_bb[2]);
            o_dbc <= DOT_W'(r2_bc[0]) + DOT_W'(r2_bc[1]) + DOT_W'(r2_bc[2]);
            o_nx  <= NRM_W'(r2_x[0]) - NRM_W'(r2_x[1]);
            o_ny  <= NRM_W'(r2_x[2]) - NRM_W'(r2_x[3]);
            o_nz  <= NRM_W'(r2_x[4]) - NRM_W'(r2_x[5]);
            o_cx  <= r2_c[0];
            o_cy  <= r2_c[1];
            o_cz  <= r2_c[2];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pit_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_decide
// plane, degeneracy and barycentric band compares into the result register
// ----------------------------------------------------------------------------
module pit_decide
    import pit_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [SQ_W-1:0]   i_ss,
    input  logic signed [TOLN_W-1:0] i_tn,
    input  logic signed [ETN_W-1:0]  i_te,
    input  logic signed [GRAM_W-1:0] i_n,
    input  logic signed [GRAM_W-1:0] i_u,
    input  logic signed [GRAM_W-1:0] i_v,
    input  logic signed [BARY_W-1:0] i_w,
    input  logic [LIM_W-1:0]         i_limit,
    output t_pit_out                 o_res
);

    logic signed [GRAM_W-1:0] lim_s;
    logic signed [CLS_W-1:0]  su;
    logic signed [CLS_W-1:0]  sv;
    logic signed [CLS_W-1:0]  sw;
    logic signed [CLS_W-1:0]  te;
    logic signed [CLS_W-1:0]  nte;
    logic                     off;
    logic                     degen;
    t_pit_out                 n_res;

    assign lim_s = GRAM_W'($signed({1'b0, i_limit}));
    assign su    = CLS_W'(i_u) <<< EDGE_FRAC;
    assign sv    = CLS_W'(i_v) <<< EDGE_FRAC;
    assign sw    = CLS_W'(i_w) <<< EDGE_FRAC;
    assign te    = CLS_W'(i_te);
    assign nte   = -te;
    assign off   = OFF_W'(i_ss) > OFF_W'(i_tn);
    assign degen = i_n <= lim_s;

    always_comb begin
        n_res.off_plane  = off;
        n_res.degenerate = degen;
        if (off || degen) begin
            n_res.region = REGION_EDGE;
        end else if (su < nte || sv < nte || sw < nte) begin
            n_res.region = REGION_OUTSIDE;
        end else if (su > te && sv > te && sw > te) begin
            n_res.region = REGION_INSIDE;
        end else begin
            n_res.region = REGION_EDGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= n_res;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/point_in_triangle_test_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_triangle_test_unit
// classifies a 3d grid point against a triangle as outside, on the edge band
// or inside, with exact barycentric arithmetic and plane / degeneracy flags
// ----------------------------------------------------------------------------
//  channel   direction  beat                       handshake
//  input     in         t_pit_in (A, B, C, P)      i_in_valid / o_in_stall
//  output    out        t_pit_out (region, flags)  o_out_valid / i_out_stall
//  config    in         apb, 3 registers at 0/4/8  psel / penable / pready
//
//  one beat a cycle enters while o_in_stall is low; each result passes through
//  the nine register stages: edge vectors, element products, dot products and
//  normal, two halves-split multiplier stages, wide sums, two more multiplier
//  stages for the squared offset and tolerances, and the final compares
//  synchronous active-low reset clears the stage valid bits and loads the
//  register reset values; payload registers are not reset
//  a stalled output holds; empty stages ahead of it still fill, so the input
//  only stalls once every stage holds a beat
// ----------------------------------------------------------------------------
module point_in_triangle_test_unit
    import pit_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input beats
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_pit_in             i_in_data,
    // result beats
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_pit_out            o_out_data,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int NUM_STAGES = 9;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [TOL_W-1:0]  r_plane_tol;
    logic [ETOL_W-1:0] r_edge_tol;
    logic [LIM_W-1:0]  r_degen_lim;
    logic [1:0]        reg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_tol <= PLANE_TOL_RESET;
            r_edge_tol  <= EDGE_TOL_RESET;
            r_degen_lim <= DEGEN_LIM_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PLANE_TOL: r_plane_tol <= pwdata[TOL_W-1:0];
                REG_EDGE_TOL:  r_edge_tol  <= pwdata[ETOL_W-1:0];
                REG_DEGEN_LIM: r_degen_lim <= pwdata[LIM_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PLANE_TOL: prdata = PDATA_W'(r_plane_tol);
            REG_EDGE_TOL:  prdata = PDATA_W'(r_edge_tol);
            REG_DEGEN_LIM: prdata = PDATA_W'(r_degen_lim);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage valid bits and per-stage advance
    // a stage may load when it is empty or the one after it moves on
    // ------------------------------------------------------------------
    logic [NUM_STAGES:1] r_v;
    logic [NUM_STAGES:1] stage_en;

    always_comb begin
        stage_en[NUM_STAGES] = !r_v[NUM_STAGES] || !i_out_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !stage_en[1];
    assign o_out_valid = r_v[NUM_STAGES];

    // ------------------------------------------------------------------
    // stages 1 to 3: edge vectors, element products, dot products and normal
    // ------------------------------------------------------------------
    logic signed [DOT_W-1:0]  daa, dab, dac, dbb, dbc;
    logic signed [NRM_W-1:0]  nx, ny, nz;
    logic signed [DIFF_W-1:0] cx, cy, cz;

    pit_front u_front (
        .i_clk  (i_clk),
        .i_en   (stage_en[3:1]),
        .i_item (i_in_data),
        .o_daa  (daa),
        .o_dab  (dab),
        .o_dac  (dac),
        .o_dbb  (dbb),
        .o_dbc  (dbc),
        .o_nx   (nx),
        .o_ny   (ny),
        .o_nz   (nz),
        .o_cx   (cx),
        .o_cy   (cy),
        .o_cz   (cz)
    );

    // ------------------------------------------------------------------
    // stages 4 and 5: dot by dot products and normal by offset products
    // ------------------------------------------------------------------
    logic signed [DD_W-1:0] p_aabb, p_abab, p_bbac, p_abbc, p_aabc, p_abac;
    logic signed [NC_W-1:0] p_nxcx, p_nycy, p_nzcz;

    pit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_aabb (
        .i_clk(i_clk), .i_en_pp(stage_en[4]), .i_en_sum(stage_en[5]),
        .i_a(daa), .i_b(dbb), .o_p(p_aabb)
    );
    pit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_abab (
        .i_clk(i_clk), .i_en_pp(stage_en[4]), .i_en_sum(stage_en[5]),
        .i_a(dab), .i_b(dab), .o_p(p_abab)
    );
    pit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bbac (
        .i_clk(i_clk), .i_en_pp(stage_en[4]), .i_en_sum(stage_en[5]),
        .i_a(dbb), .i_b(dac), .o_p(p_bbac)
    );
    pit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_abbc (
        .i_clk(i_clk), .i_en_pp(stage_en[4]), .i_en_sum(stage_en[5]),
        .i_a(dab), .i_b(dbc), .o_p(p_abbc)
    );
    pit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_aabc (
        .i_clk(i_clk), .i_en_pp(stage_en[4]), .i_en_sum(stage_en[5]),
        .i_a(daa), .i_b(dbc), .o_p(p_aabc)
    );
    pit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_abac (
        .i_clk(i_clk), .i_en_pp(stage_en[4]), .i_en_sum(stage_en[5]),
        .i_a(dab), .i_b(dac), .o_p(p_abac)
    );
    pit_mul #(.AW(NRM_W), .BW(DIFF_W)) u_mul_nxcx (
        .i_clk(i_clk), .i_en_pp(stage_en[4]), .i_en_sum(stage_en[5]),
        .i_a(nx), .i_b(cx), .o_p(p_nxcx)
    );
    pit_mul #(.AW(NRM_W), .BW(DIFF_W)) u_mul_nycy (
        .i_clk(i_clk), .i_en_pp(stage_en[4]), .i_en_sum(stage_en[5]),
        .i_a(ny), .i_b(cy), .o_p(p_nycy)
    );
    pit_mul #(.AW(NRM_W), .BW(DIFF_W)) u_mul_nzcz (
        .i_clk(i_clk), .i_en_pp(stage_en[4]), .i_en_sum(stage_en[5]),
        .i_a(nz), .i_b(cz), .o_p(p_nzcz)
    );

    // ------------------------------------------------------------------
    // stage 6: gram determinant n = |N|^2, barycentric numerators u and v,
    // and the plane offset numerator s = N.c
    // ------------------------------------------------------------------
    logic signed [GRAM_W-1:0]  r6_n, r6_u, r6_v;
    logic signed [PLANE_W-1:0] r6_s;

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            r6_n <= GRAM_W'(p_aabb) - GRAM_W'(p_abab);
            r6_u <= GRAM_W'(p_bbac) - GRAM_W'(p_abbc);
            r6_v <= GRAM_W'(p_aabc) - GRAM_W'(p_abac);
            r6_s <= PLANE_W'(p_nxcx) + PLANE_W'(p_nycy) + PLANE_W'(p_nzcz);
        end
    end

    // ------------------------------------------------------------------
    // stages 7 and 8: s^2, plane tolerance times n, edge band times n;
    // w = n - u - v formed alongside and carried with n, u, v
    // ------------------------------------------------------------------
    logic signed [TOL_W:0]     tol_s;
    logic signed [ETOL_W:0]    etol_s;
    logic signed [SQ_W-1:0]    p_ss;
    logic signed [TOLN_W-1:0]  p_tn;
    logic signed [ETN_W-1:0]   p_te;
    logic signed [GRAM_W-1:0]  r7_n, r7_u, r7_v;
    logic signed [BARY_W-1:0]  r7_w;
    logic signed [GRAM_W-1:0]  r8_n, r8_u, r8_v;
    logic signed [BARY_W-1:0]  r8_w;

    // registers are unsigned, so they enter the multipliers with a zero sign bit
    assign tol_s  = $signed({1'b0, r_plane_tol});
    assign etol_s = $signed({1'b0, r_edge_tol});

    pit_mul #(.AW(PLANE_W), .BW(PLANE_W)) u_mul_ss (
        .i_clk(i_clk), .i_en_pp(stage_en[7]), .i_en_sum(stage_en[8]),
        .i_a(r6_s), .i_b(r6_s), .o_p(p_ss)
    );
    pit_mul #(.AW(TOL_W + 1), .BW(GRAM_W)) u_mul_tn (
        .i_clk(i_clk), .i_en_pp(stage_en[7]), .i_en_sum(stage_en[8]),
        .i_a(tol_s), .i_b(r6_n), .o_p(p_tn)
    );
    pit_mul #(.AW(ETOL_W + 1), .BW(GRAM_W)) u_mul_te (
        .i_clk(i_clk), .i_en_pp(stage_en[7]), .i_en_sum(stage_en[8]),
        .i_a(etol_s), .i_b(r6_n), .o_p(p_te)
    );

    always_ff @(posedge i_clk) begin
        if (stage_en[7]) begin
            r7_n <= r6_n;
            r7_u <= r6_u;
            r7_v <= r6_v;
            r7_w <= BARY_W'(r6_n) - BARY_W'(r6_u) - BARY_W'(r6_v);
        end
        if (stage_en[8]) begin
            r8_n <= r7_n;
            r8_u <= r7_u;
            r8_v <= r7_v;
            r8_w <= r7_w;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: classification into the output register
    // ------------------------------------------------------------------
    pit_decide u_decide (
        .i_clk   (i_clk),
        .i_en    (stage_en[9]),
        .i_ss    (p_ss),
        .i_tn    (p_tn),
        .i_te    (p_te),
        .i_n     (r8_n),
        .i_u     (r8_u),
        .i_v     (r8_v),
        .i_w     (r8_w),
        .i_limit (r_degen_lim),
        .o_res   (o_out_data)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // input only backs up when the whole pipe is full and the output blocked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r_v[1]))
        else $error("input stalled with room in the pipe");

    // reset empties the output stage
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // a flagged result is always reported on the edge band
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.off_plane || o_out_data.degenerate))
        |-> (o_out_data.region == REGION_EDGE))
        else $error("flagged result not on edge band");

    // a beat in stage 8 moves into the output when the output is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NUM_STAGES-1] && stage_en[NUM_STAGES]) |=> o_out_valid)
        else $error("beat lost before the output stage");

    // region is never the unused code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.region == REGION_OUTSIDE
                         || o_out_data.region == REGION_EDGE
                         || o_out_data.region == REGION_INSIDE))
        else $error("invalid region code");

endmodule
`default_nettype wire

// ===== tb/sv/point_in_triangle_test_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_triangle_test_unit_test
// self-checking bench: drives triangle and query point beats through the
// unit, predicts each verdict with exact wide arithmetic and compares every
// result beat field by field, across several threshold settings
// ----------------------------------------------------------------------------
module point_in_triangle_test_unit_test;
    import pit_pkg::*;

    // register stages that each result passes through in the pipe
    localparam int PIPE_DEPTH     = 9;
    // cycles with no beat moving on either channel before giving up
    localparam int WATCHDOG_LIMIT = 2000;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES    = 100;
    localparam int PHASE_ITEMS    = 120;
    localparam int C_MIN          = -32768;
    localparam int C_MAX          = 32767;

    // register index with no register behind it
    localparam logic [1:0] REG_SPARE = 2'd3;

    // wide enough for the squared plane offset and every scaled numerator
    typedef logic signed [255:0] exact_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_pit_in             i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_pit_out            o_out_data;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    point_in_triangle_test_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    // our own copy of the threshold registers
    logic [TOL_W-1:0]  plane_tol_q = PLANE_TOL_RESET;
    logic [ETOL_W-1:0] edge_tol_q  = EDGE_TOL_RESET;
    logic [LIM_W-1:0]  degen_lim_q = DEGEN_LIM_RESET;

    // verdicts predicted for accepted beats, oldest first
    t_pit_out pending_verdicts[$];

    int  check_errors  = 0;
    int  reg_errors    = 0;
    int  idle_cycles   = 0;
    // idling controls, set by the test sequence
    bit  in_gaps_on    = 1'b0;
    bit  out_stalls_on = 1'b0;
    int  hold_requests = 0;
    // shadow of the input valid, so it is only lowered once per step
    bit  valid_up      = 1'b0;

    // ------------------------------------------------------------------------
    // verdict predictor: exact integer barycentric test, divisions multiplied
    // out, same thresholds as the block
    // ------------------------------------------------------------------------
    function automatic t_pit_out classify_point(input t_pit_in q);
        exact_t   org[3], e_ba[3], e_ca[3], e_pa[3];
        exact_t   daa, dab, dac, dbb, dbc, nx, ny, nz;
        exact_t   gram, offset, tol_x, lim_x, band, num_u, num_v, num_w;
        t_pit_out verdict;
        org[0]  = exact_t'(q.ax);
        org[1]  = exact_t'(q.ay);
        org[2]  = exact_t'(q.az);
        e_ba[0] = exact_t'(q.bx) - org[0];
        e_ba[1] = exact_t'(q.by_coord) - org[1];
        e_ba[2] = exact_t'(q.bz) - org[2];
        e_ca[0] = exact_t'(q.cx) - org[0];
        e_ca[1] = exact_t'(q.cy) - org[1];
        e_ca[2] = exact_t'(q.cz) - org[2];
        e_pa[0] = exact_t'(q.px) - org[0];
        e_pa[1] = exact_t'(q.py) - org[1];
        e_pa[2] = exact_t'(q.pz) - org[2];
        daa = '0;
        dab = '0;
        dac = '0;
        dbb = '0;
        dbc = '0;
        for (int k = 0; k < 3; k++) begin
            daa += e_ca[k] * e_ca[k];
            dab += e_ca[k] * e_ba[k];
            dac += e_ca[k] * e_pa[k];
            dbb += e_ba[k] * e_ba[k];
            dbc += e_ba[k] * e_pa[k];
        end
        // normal is (C - A) x (B - A)
        nx = e_ca[1] * e_ba[2] - e_ca[2] * e_ba[1];
        ny = e_ca[2] * e_ba[0] - e_ca[0] * e_ba[2];
        nz = e_ca[0] * e_ba[1] - e_ca[1] * e_ba[0];
        gram   = daa * dbb - dab * dab;
        offset = nx * e_pa[0] + ny * e_pa[1] + nz * e_pa[2];
        tol_x  = exact_t'(plane_tol_q);
        lim_x  = exact_t'(degen_lim_q);
        verdict.off_plane  = (offset * offset > tol_x * gram);
        verdict.degenerate = (gram <= lim_x);
        if (verdict.off_plane || verdict.degenerate) begin
            verdict.region = REGION_EDGE;
        end else begin
            num_u = dbb * dac - dab * dbc;
            num_v = daa * dbc - dab * dac;
            num_w = gram - num_u - num_v;
            // compare in q0.16 against the band edge_tol * gram
            num_u = num_u * 65536;
            num_v = num_v * 65536;
            num_w = num_w * 65536;
            band  = exact_t'(edge_tol_q);
            band  = band * gram;
            if (num_u < -band || num_v < -band || num_w < -band) begin
                verdict.region = REGION_OUTSIDE;
            end else if (num_u > band && num_v > band && num_w > band) begin
                verdict.region = REGION_INSIDE;
            end else begin
                verdict.region = REGION_EDGE;
            end
        end
        return verdict;
    endfunction

    // ------------------------------------------------------------------------
    // beat builders
    // ------------------------------------------------------------------------
    function automatic t_pit_in tri_query(input int ax, ay, az, bx, by_coord, bz,
                                          input int cx, cy, cz, px, py, pz);
        t_pit_in q;
        q.ax       = COORD_WIDTH'(ax);
        q.ay       = COORD_WIDTH'(ay);
        q.az       = COORD_WIDTH'(az);
        q.bx       = COORD_WIDTH'(bx);
        q.by_coord = COORD_WIDTH'(by_coord);
        q.bz       = COORD_WIDTH'(bz);
        q.cx       = COORD_WIDTH'(cx);
        q.cy       = COORD_WIDTH'(cy);
        q.cz       = COORD_WIDTH'(cz);
        q.px       = COORD_WIDTH'(px);
        q.py       = COORD_WIDTH'(py);
        q.pz       = COORD_WIDTH'(pz);
        return q;
    endfunction

    // mostly points on a lattice in the triangle's own plane, so inside, edge
    // and outside all turn up; some nudged off the plane, some collinear
    // triangles, and raw noise over every bit
    function automatic t_pit_in random_query();
        int kind, d, span, i, j, k;
        int org[3], ea[3], eb[3], pt[3];
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            return t_pit_in'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end
        d = $urandom_range(1, 16);
        case ($urandom_range(0, 3))
            0: begin
                span = 2;
            end
            1: begin
                span = 20;
            end
            2: begin
                span = 200;
            end
            default: begin
                span = 600;
            end
        endcase
        for (k = 0; k < 3; k++) begin
            org[k] = int'($urandom_range(0, 16000)) - 8000;
            ea[k]  = int'($urandom_range(0, 2 * span)) - span;
            eb[k]  = int'($urandom_range(0, 2 * span)) - span;
        end
        // collinear or coincident vertices
        if (kind < 28) begin
            j = int'($urandom_range(0, 3)) - 1;
            for (k = 0; k < 3; k++) eb[k] = ea[k] * j;
        end
        // barycentric coordinates i/d and j/d, some beyond the triangle
        i = int'($urandom_range(0, 2 * d + 2)) - d / 2 - 1;
        j = int'($urandom_range(0, 2 * d + 2)) - d / 2 - 1;
        for (k = 0; k < 3; k++) pt[k] = org[k] + i * ea[k] + j * eb[k];
        // just off the plane, for the plane tolerance
        if (kind >= 28 && kind < 45) begin
            k = $urandom_range(0, 2);
            pt[k] += int'($urandom_range(0, 6)) - 3;
        end
        return tri_query(org[0], org[1], org[2],
                         org[0] + d * eb[0], org[1] + d * eb[1], org[2] + d * eb[2],
                         org[0] + d * ea[0], org[1] + d * ea[1], org[2] + d * ea[2],
                         pt[0], pt[1], pt[2]);
    endfunction

    // ------------------------------------------------------------------------
    // register port helpers
    // ------------------------------------------------------------------------
    function automatic logic [PADDR_W-1:0] reg_addr(input logic [1:0] idx);
        return {idx, 2'b00};
    endfunction

    function automatic logic [PDATA_W-1:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_PLANE_TOL: begin
                return PDATA_W'(plane_tol_q);
            end
            REG_EDGE_TOL: begin
                return PDATA_W'(edge_tol_q);
            end
            REG_DEGEN_LIM: begin
                return PDATA_W'(degen_lim_q);
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    // setup phase, access phase, then the bus is left idle
    task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        case (idx)
            REG_PLANE_TOL: begin
                plane_tol_q = data[TOL_W-1:0];
            end
            REG_EDGE_TOL: begin
                edge_tol_q = data[ETOL_W-1:0];
            end
            REG_DEGEN_LIM: begin
                degen_lim_q = data[LIM_W-1:0];
            end
            default: begin
                // no register there, nothing changes
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [1:0] idx);
        logic [PDATA_W-1:0] want;
        want    = reg_value(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: register %0d read expected %h got %h", $time, idx, want, prdata);
            reg_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // input channel
    // ------------------------------------------------------------------------
    // offers one beat and returns at the edge that takes it, valid left high
    task automatic send_query(input t_pit_in q);
        if (in_gaps_on && $urandom_range(0, 4) == 0) begin
            if (valid_up) begin
                i_in_valid <= 1'b0;
                valid_up   = 1'b0;
            end
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        valid_up   = 1'b1;
        i_in_data  <= q;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pending_verdicts.push_back(classify_point(q));
    endtask

    // stop offering and wait until every predicted verdict has come back
    task automatic drain_results();
        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up   = 1'b0;
        end
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // thresholds only change with the pipe empty
    task automatic set_thresholds(input logic [PDATA_W-1:0] tol,
                                  input logic [PDATA_W-1:0] etol,
                                  input logic [PDATA_W-1:0] lim);
        drain_results();
        apb_write(REG_PLANE_TOL, tol);
        apb_write(REG_EDGE_TOL, etol);
        apb_write(REG_DEGEN_LIM, lim);
    endtask

    // ------------------------------------------------------------------------
    // output channel: random stall bursts, plus the long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_out_stall
        int   holds_served;
        int   hold_left;
        int   burst_left;
        logic stall_next;
        stall_next = 1'b0;
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            stall_next = 1'b0;
        end else if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
        end else if (burst_left > 0) begin
            stall_next = 1'b1;
            burst_left--;
        end else if (out_stalls_on && $urandom_range(0, 7) == 0) begin
            stall_next = 1'b1;
            burst_left = $urandom_range(1, 12) - 1;
        end
        i_out_stall <= stall_next;
    end

    // every result beat against the oldest prediction
    always @(posedge i_clk) begin : check_verdict
        t_pit_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result beat expected none got %p", $time, o_out_data);
                check_errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_out_data.region !== want.region) begin
                    $display("%0t: region expected %0d got %0d",
                             $time, want.region, o_out_data.region);
                    check_errors++;
                end
                if (o_out_data.off_plane !== want.off_plane) begin
                    $display("%0t: off_plane expected %0d got %0d",
                             $time, want.off_plane, o_out_data.off_plane);
                    check_errors++;
                end
                if (o_out_data.degenerate !== want.degenerate) begin
                    $display("%0t: degenerate expected %0d got %0d",
                             $time, want.degenerate, o_out_data.degenerate);
                    check_errors++;
                end
            end
        end
    end

    // watchdog: too long with no beat moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset values, full-width writes, upper bits dropped, unused index ignored
    task automatic test_register_access();
        apb_read(REG_PLANE_TOL);
        apb_read(REG_EDGE_TOL);
        apb_read(REG_DEGEN_LIM);
        apb_write(REG_PLANE_TOL, '1);
        apb_write(REG_EDGE_TOL, 32'hABCD_1234);
        apb_write(REG_DEGEN_LIM, '1);
        apb_write(REG_SPARE, 32'h1234_5678);
        apb_read(REG_PLANE_TOL);
        apb_read(REG_EDGE_TOL);
        apb_read(REG_DEGEN_LIM);
        set_thresholds(PLANE_TOL_RESET, PDATA_W'(EDGE_TOL_RESET), DEGEN_LIM_RESET);
        apb_read(REG_EDGE_TOL);
    endtask

    // coordinates at the ends of their range, at reset thresholds
    task automatic test_coordinate_extremes();
        // large right triangle across the whole grid in z = min
        send_query(tri_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                             C_MIN + 1000, C_MIN + 1000, C_MIN));
        send_query(tri_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                             C_MIN, C_MIN, C_MIN));
        send_query(tri_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                             0, 0, C_MIN));
        send_query(tri_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                             C_MAX, C_MAX, C_MIN));
        send_query(tri_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                             C_MIN + 1000, C_MIN + 1000, C_MAX));
        // mirrored, anchored at the top corner
        send_query(tri_query(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX,
                             0, 0, C_MAX));
        // every vertex the same point
        send_query(tri_query(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                             C_MAX, C_MAX, C_MAX));
        send_query(tri_query(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                             C_MIN, C_MIN, C_MIN));
        // alternating bit patterns
        send_query(tri_query(21845, -21846, 21845, -21846, 21845, -21846,
                             21845, -21846, 21845, -21846, 21845, -21846));
        send_query(tri_query(-21846, 21845, -21846, 21845, -21846, 21845,
                             -21846, 21845, -21846, 21845, -21846, 21845));
        // collinear vertices
        send_query(tri_query(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 1, 1));
        // triangle standing in the x = 0 plane
        send_query(tri_query(0, 0, 0, 0, 0, 8, 0, 8, 0, 0, 2, 2));
        send_query(tri_query(0, 0, 0, 0, 0, 8, 0, 8, 0, 3, 2, 2));
    endtask

    // flags on their own and together, and the exact threshold boundaries
    task automatic test_flag_cases();
        // unit triangle, gram 1, point five units above it
        set_thresholds(0, 1, 100);
        send_query(tri_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 5));
        // squared offset 25 against tolerance 25, then 24
        set_thresholds(25, 1, 0);
        send_query(tri_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 5));
        set_thresholds(24, 1, 0);
        send_query(tri_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 5));
        // 4x4 right triangle has gram 256
        set_thresholds(0, 1, 256);
        send_query(tri_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, 1, 0));
        set_thresholds(0, 1, 255);
        send_query(tri_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, 1, 0));
        // no edge band at all
        set_thresholds(0, 0, 0);
        send_query(tri_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 2, 2, 0));
        send_query(tri_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, 1, 0));
        send_query(tri_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 0, 5, 0));
        // widest band swallows the inside
        set_thresholds(0, 32'hFFFF, 0);
        send_query(tri_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, 1, 0));
        send_query(tri_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 5, 5, 0));
    endtask

    // bulk of the run: random beats under a series of threshold settings
    task automatic test_random_thresholds();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    set_thresholds(PLANE_TOL_RESET, PDATA_W'(EDGE_TOL_RESET),
                                   DEGEN_LIM_RESET);
                end
                1: begin
                    set_thresholds('1, '1, '1);
                end
                2: begin
                    set_thresholds($urandom_range(0, 16), 0, 0);
                end
                3: begin
                    set_thresholds(0, 32'hFFFF, 0);
                end
                4: begin
                    set_thresholds($urandom, $urandom, $urandom_range(0, 4096));
                end
                5: begin
                    set_thresholds(4, 32'h2000, $urandom);
                end
                6: begin
                    set_thresholds(1, 32'h8000, 1);
                end
                default: begin
                    set_thresholds($urandom, $urandom_range(0, 65535), $urandom);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // reshuffle idling on each side every few dozen beats
                if (n % 30 == 0) begin
                    in_gaps_on    = 1'($urandom_range(0, 1));
                    out_stalls_on = 1'($urandom_range(0, 1));
                end
                send_query(random_query());
            end
        end
    endtask

    // receiver holds off while beats keep coming, so the pipe fills and
    // pushes back on the input
    task automatic test_output_hold();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        hold_requests++;
        repeat (40) send_query(random_query());
    endtask

    // sender stops until everything is back, then resumes
    task automatic test_sender_pause();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        repeat (30) send_query(random_query());
        drain_results();
        repeat (30) send_query(random_query());
    endtask

    // last stretch at full rate on both sides
    task automatic test_quiet_stream();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        repeat (60) send_query(random_query());
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        test_register_access();
        test_coordinate_extremes();
        test_flag_cases();
        test_random_thresholds();
        test_output_hold();
        test_sender_pause();
        test_quiet_stream();
        drain_results();
        // tail, to catch any stray result beats
        repeat (2 * PIPE_DEPTH + 2) @(posedge i_clk);
        if (check_errors == 0 && reg_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== point_in_triangle_test_unit.f =====
rtl/pit_pkg.sv
rtl/pit_mul.sv
rtl/pit_front.sv
rtl/pit_decide.sv
rtl/point_in_triangle_test_unit.sv
tb/sv/point_in_triangle_test_unit_test.sv
